// File: rtl/value_noise_3d_top_defines.svh
// Assertion macros shared by the checker files of this block.
`ifndef VALUE_NOISE_3D_TOP_DEFINES_SVH
`define VALUE_NOISE_3D_TOP_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent, outside reset.
`define VN3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define VN3_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Checked during reset as well.
`define VN3_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/vn3_pkg.sv
package vn3_pkg;

  typedef logic [63:0] hash_t;

  localparam hash_t MIX_ADD  = 64'h9e3779b97f4a7c15;
  localparam hash_t MIX_MUL1 = 64'hbf58476d1ce4e5b9;
  localparam hash_t MIX_MUL2 = 64'h94d049bb133111eb;

  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_WORLD_SEED  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CELL_PERIOD = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_HASH_SALT   = 2'd2;

  // 3.0 in Q16, the constant term of the smoothstep polynomial.
  localparam logic [17:0] SHAPE_THREE = 18'd196608;
  // Added to a negative Q16 product so the shift truncates toward zero.
  localparam logic signed [33:0] TRUNC_BIAS = 34'sd65535;

endpackage

// File: rtl/vn3_in_if.sv
interface vn3_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;

  modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

// File: rtl/vn3_out_if.sv
interface vn3_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink (input valid, input noise_value, output ready);
endinterface

// File: rtl/vn3_cfg_if.sv
interface vn3_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [vn3_pkg::REG_IDX_W-1:0] index;
  logic [63:0]                   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/vn3_mix.sv
// Five-stage splitmix64 finalizer over (din ^ key). Each 64-bit product keeps
// its low half only, built from three 32x32 partial products.
module vn3_mix (
  input  logic           clk,
  input  logic           en,
  input  vn3_pkg::hash_t din,
  input  vn3_pkg::hash_t key,
  output vn3_pkg::hash_t dout
);

  vn3_pkg::hash_t v1;
  vn3_pkg::hash_t p1_lo;
  logic [31:0]    p1_c1;
  logic [31:0]    p1_c2;
  vn3_pkg::hash_t v3;
  vn3_pkg::hash_t p2_lo;
  logic [31:0]    p2_c1;
  logic [31:0]    p2_c2;

  vn3_pkg::hash_t x1;
  vn3_pkg::hash_t x2;
  vn3_pkg::hash_t s1;
  vn3_pkg::hash_t s2;

  always_comb begin
    x1 = v1 ^ (v1 >> 30);
    s1 = p1_lo + {p1_c1 + p1_c2, 32'd0};
    x2 = v3 ^ (v3 >> 27);
    s2 = p2_lo + {p2_c1 + p2_c2, 32'd0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1    <= (din ^ key) + vn3_pkg::MIX_ADD;
      p1_lo <= {32'd0, x1[31:0]} * {32'd0, vn3_pkg::MIX_MUL1[31:0]};
      p1_c1 <= x1[31:0] * vn3_pkg::MIX_MUL1[63:32];
      p1_c2 <= x1[63:32] * vn3_pkg::MIX_MUL1[31:0];
      v3    <= s1;
      p2_lo <= {32'd0, x2[31:0]} * {32'd0, vn3_pkg::MIX_MUL2[31:0]};
      p2_c1 <= x2[31:0] * vn3_pkg::MIX_MUL2[63:32];
      p2_c2 <= x2[63:32] * vn3_pkg::MIX_MUL2[31:0];
      dout  <= s2 ^ (s2 >> 31);
    end
  end

endmodule

// File: rtl/vn3_div.sv
// Restoring divider, one quotient bit per stage. The remainder starts at
// rem0, which must be below den; the NW bits of num are shifted in.
module vn3_div #(
  parameter int NW = 31,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [DW-1:0] rem0,
  output logic [NW-1:0] quo,
  output logic [DW-1:0] rem
);

  logic [DW-1:0] rem_q [NW];
  logic [NW-1:0] nq_q  [NW];
  logic [DW-1:0] den_q [NW];

  logic [DW-1:0] rem_p [NW];
  logic [NW-1:0] nq_p  [NW];
  logic [DW-1:0] den_p [NW];
  logic [DW-1:0] rem_d [NW];
  logic [NW-1:0] nq_d  [NW];

  always_comb begin
    logic [DW:0] t;
    logic        ge;
    rem_p[0] = rem0;
    nq_p[0]  = num;
    den_p[0] = den;
    for (int i = 1; i < NW; i++) begin
      rem_p[i] = rem_q[i-1];
      nq_p[i]  = nq_q[i-1];
      den_p[i] = den_q[i-1];
    end
    for (int i = 0; i < NW; i++) begin
      t  = {rem_p[i], nq_p[i][NW-1]};
      ge = t >= {1'b0, den_p[i]};
      rem_d[i] = ge ? DW'(t - {1'b0, den_p[i]}) : t[DW-1:0];
      nq_d[i]  = {nq_p[i][NW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NW; i++) begin
        rem_q[i] <= rem_d[i];
        nq_q[i]  <= nq_d[i];
        den_q[i] <= den_p[i];
      end
    end
  end

  assign quo = nq_q[NW-1];
  assign rem = rem_q[NW-1];

endmodule

// File: rtl/value_noise_3d_top.sv
// 3D value noise: one signed position beat in, one 16-bit noise sample beat
// out, one sample accepted per clock unless the result channel stalls. A
// sample passes 58 register stages: 31 divider stages find the floor cell,
// one stage mirrors negative coordinates back, four chained hash rounds of
// five stages each run on the corner cells while 18 stages form and shape
// the Q16 fraction, and six stages blend the corners along x, y and z. Back
// pressure on the result channel freezes the whole pipeline; nothing else
// stalls it. Configuration writes are always taken and must only be issued
// while no sample is in flight.
module value_noise_3d_top #(
  parameter int PERIOD_BITS = 16
) (
  input logic      clk,
  input logic      rst,
  vn3_in_if.sink   samples,
  vn3_out_if.source results,
  vn3_cfg_if.sink  cfg
);

  localparam int PW  = (PERIOD_BITS < 16) ? PERIOD_BITS : 16;
  localparam int LAT = 58;

  logic [31:0] world_seed;
  logic [15:0] cell_period;
  logic [63:0] hash_salt;

  logic [PW-1:0] period;
  logic          adv;
  logic [LAT-1:0] vld;

  assign period        = cell_period[PW-1:0];
  assign adv           = !vld[LAT-1] || results.ready;
  assign samples.ready = adv;
  assign cfg.ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      world_seed  <= 32'd0;
      cell_period <= 16'd16;
      hash_salt   <= 64'd0;
    end else if (cfg.valid) begin
      case (cfg.index)
        vn3_pkg::REG_WORLD_SEED:  world_seed  <= cfg.data[31:0];
        vn3_pkg::REG_CELL_PERIOD: cell_period <= cfg.data[15:0];
        vn3_pkg::REG_HASH_SALT:   hash_salt   <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], samples.valid};
    end
  end

  // Floor division: a negative coordinate p is divided as ~p = -p-1, and
  // the quotient and remainder are mirrored back afterward.
  logic [31:0] pos [3];
  logic [2:0]  neg;
  logic [30:0] mag [3];

  always_comb begin
    pos[0] = samples.pos_x;
    pos[1] = samples.pos_y;
    pos[2] = samples.pos_z;
    for (int c = 0; c < 3; c++) begin
      neg[c] = pos[c][31];
      mag[c] = neg[c] ? ~pos[c][30:0] : pos[c][30:0];
    end
  end

  logic [30:0]   q0 [3];
  logic [PW-1:0] r0 [3];
  logic [2:0]    neg_dl [31];

  logic [31:0]   base_cell [3];
  logic [PW-1:0] loc  [3];
  logic [15:0]   frac [3];
  logic [15:0]   a2   [3];
  logic [17:0]   shk  [3];
  logic [15:0]   alpha [3];

  for (genvar c = 0; c < 3; c++) begin : g_coord
    vn3_div #(.NW(31), .DW(PW)) u_floor (
      .clk  (clk),
      .en   (adv),
      .num  (mag[c]),
      .den  (period),
      .rem0 ({PW{1'b0}}),
      .quo  (q0[c]),
      .rem  (r0[c])
    );

    vn3_div #(.NW(16), .DW(PW)) u_frac (
      .clk  (clk),
      .en   (adv),
      .num  (16'd0),
      .den  (period),
      .rem0 (loc[c]),
      .quo  (frac[c]),
      .rem  ()
    );
  end

  logic [31:0] sq [3];
  logic [33:0] sp [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sq[c] = {16'd0, frac[c]} * {16'd0, frac[c]};
      sp[c] = {18'd0, a2[c]} * {16'd0, shk[c]};
    end
  end

  // Seed round depends on configuration only, so it runs freely.
  vn3_pkg::hash_t h_seed;
  vn3_mix u_mix_seed (
    .clk  (clk),
    .en   (1'b1),
    .din  ({32'd0, world_seed}),
    .key  (64'd0),
    .dout (h_seed)
  );

  logic [31:0] cy_dl [5];
  logic [31:0] cz_dl [10];
  vn3_pkg::hash_t hx [2];
  vn3_pkg::hash_t hy [4];
  vn3_pkg::hash_t hz [8];
  vn3_pkg::hash_t hs [8];

  for (genvar dx = 0; dx < 2; dx++) begin : g_mx
    vn3_mix u_mix (
      .clk  (clk),
      .en   (adv),
      .din  (h_seed),
      .key  ({32'd0, base_cell[0] + 32'(dx)}),
      .dout (hx[dx])
    );
  end

  for (genvar j = 0; j < 4; j++) begin : g_my
    vn3_mix u_mix (
      .clk  (clk),
      .en   (adv),
      .din  (hx[j % 2]),
      .key  ({32'd0, cy_dl[4] + 32'(j / 2)}),
      .dout (hy[j])
    );
  end

  for (genvar k = 0; k < 8; k++) begin : g_mz
    vn3_mix u_mix (
      .clk  (clk),
      .en   (adv),
      .din  (hy[k % 4]),
      .key  ({32'd0, cz_dl[9] + 32'(k / 4)}),
      .dout (hz[k])
    );
  end

  for (genvar k = 0; k < 8; k++) begin : g_ms
    vn3_mix u_mix (
      .clk  (clk),
      .en   (adv),
      .din  (hz[k]),
      .key  (hash_salt),
      .dout (hs[k])
    );
  end

  function automatic logic [15:0] blend_fin(logic [15:0] base, logic signed [33:0] prod);
    logic signed [33:0] adj;
    adj = prod[33] ? prod + vn3_pkg::TRUNC_BIAS : prod;
    return base + adj[31:16];
  endfunction

  logic [15:0] ax_dl [2];
  logic [15:0] ay_dl [4];
  logic [15:0] az_dl [6];

  logic signed [15:0] corner [8];
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      corner[k] = {~hs[k][15], hs[k][14:0]};
    end
  end

  logic signed [33:0] xprod [4];
  logic [15:0]        xbase [4];
  logic [15:0]        yv    [4];
  logic signed [33:0] yprod [2];
  logic [15:0]        ybase [2];
  logic [15:0]        zv    [2];
  logic signed [33:0] zprod;
  logic [15:0]        zbase;
  logic [15:0]        result;

  logic signed [16:0] xdiff [4];
  logic signed [16:0] ydiff [2];
  logic signed [16:0] zdiff;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      xdiff[i] = {corner[2*i+1][15], corner[2*i+1]} - {corner[2*i][15], corner[2*i]};
    end
    for (int i = 0; i < 2; i++) begin
      ydiff[i] = {yv[2*i+1][15], yv[2*i+1]} - {yv[2*i][15], yv[2*i]};
    end
    zdiff = {zv[1][15], zv[1]} - {zv[0][15], zv[0]};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      neg_dl[0] <= neg;
      for (int i = 1; i < 31; i++) begin
        neg_dl[i] <= neg_dl[i-1];
      end

      for (int c = 0; c < 3; c++) begin
        base_cell[c] <= neg_dl[30][c] ? ~{1'b0, q0[c]} : {1'b0, q0[c]};
        loc[c]       <= neg_dl[30][c] ? PW'(period - r0[c] - PW'(1)) : r0[c];
        a2[c]        <= sq[c][31:16];
        shk[c]       <= vn3_pkg::SHAPE_THREE - {1'b0, frac[c], 1'b0};
        alpha[c]     <= sp[c][31:16];
      end

      cy_dl[0] <= base_cell[1];
      for (int i = 1; i < 5; i++) begin
        cy_dl[i] <= cy_dl[i-1];
      end
      cz_dl[0] <= base_cell[2];
      for (int i = 1; i < 10; i++) begin
        cz_dl[i] <= cz_dl[i-1];
      end

      ax_dl[0] <= alpha[0];
      ax_dl[1] <= ax_dl[0];
      ay_dl[0] <= alpha[1];
      for (int i = 1; i < 4; i++) begin
        ay_dl[i] <= ay_dl[i-1];
      end
      az_dl[0] <= alpha[2];
      for (int i = 1; i < 6; i++) begin
        az_dl[i] <= az_dl[i-1];
      end

      for (int i = 0; i < 4; i++) begin
        xprod[i] <= 34'(xdiff[i]) * 34'($signed({1'b0, ax_dl[1]}));
        xbase[i] <= corner[2*i];
        yv[i]    <= blend_fin(xbase[i], xprod[i]);
      end
      for (int i = 0; i < 2; i++) begin
        yprod[i] <= 34'(ydiff[i]) * 34'($signed({1'b0, ay_dl[3]}));
        ybase[i] <= yv[2*i];
        zv[i]    <= blend_fin(ybase[i], yprod[i]);
      end
      zprod  <= 34'(zdiff) * 34'($signed({1'b0, az_dl[5]}));
      zbase  <= zv[0];
      result <= (period == '0) ? 16'd0 : blend_fin(zbase, zprod);
    end
  end

  assign results.valid       = vld[LAT-1];
  assign results.noise_value = result;

endmodule

// File: rtl/vn3_checker.sv
`include "value_noise_3d_top_defines.svh"

module vn3_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] noise_value
);

  `VN3_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `VN3_ASSERT_NEXT(a_hold_data, out_valid && !out_ready, $stable(noise_value), "result changed while stalled")
  `VN3_ASSERT_NOW(a_ready_rule, in_valid || !in_valid, in_ready == (!out_valid || out_ready), "input ready does not follow output stall")
  `VN3_ASSERT_RST(a_reset_clear, rst, !out_valid, "result valid after reset")

endmodule

bind value_noise_3d_top vn3_checker u_vn3_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (samples.valid),
  .in_ready    (samples.ready),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .noise_value (results.noise_value)
);

// File: bench/tb_value_noise_3d_top.sv
module tb_value_noise_3d_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Golden model of the noise pipeline, kept in plain 64-bit arithmetic.
  class noise_scoreboard;
    logic [31:0] seed;
    logic [15:0] period;
    logic [63:0] salt;
    logic [15:0] pending[$];
    int errors;

    function new();
      seed = '0;
      period = 16;
      salt = '0;
      errors = 0;
    endfunction

    function logic [63:0] mix(logic [63:0] v);
      logic [63:0] t;
      t = v + vn3_pkg::MIX_ADD;
      t = (t ^ (t >> 30)) * vn3_pkg::MIX_MUL1;
      t = (t ^ (t >> 27)) * vn3_pkg::MIX_MUL2;
      return t ^ (t >> 31);
    endfunction

    function longint corner(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
      logic [63:0] h;
      h = mix({32'd0, seed});
      h = mix(h ^ {32'd0, cx});
      h = mix(h ^ {32'd0, cy});
      h = mix(h ^ {32'd0, cz});
      h = mix(h ^ salt);
      return longint'({48'd0, h[15:0]}) - 32768;
    endfunction

    function longint lerp(longint a, longint b, longint alpha);
      return a + (b - a) * alpha / 65536;
    endfunction

    // Floor cell of one coordinate; the smoothstep weight goes to alpha.
    function longint cell_of(logic [31:0] p, longint per, output longint alpha);
      longint pos, q, a, a2;
      pos = longint'(signed'(p));
      q = pos / per;
      if (pos % per < 0) q -= 1;
      a = (pos - q * per) * 65536 / per;
      a2 = a * a / 65536;
      alpha = a2 * (196608 - 2 * a) / 65536;
      return q;
    endfunction

    function void note_sample(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      longint per, ax, ay, az, bx, by, bz, y0, y1, z0, z1, r;
      logic [31:0] cx0, cx1, cy, cz;
      per = longint'(period);
      if (per == 0) begin
        pending.push_back('0);
        return;
      end
      bx = cell_of(x, per, ax);
      by = cell_of(y, per, ay);
      bz = cell_of(z, per, az);
      cx0 = bx[31:0];
      cx1 = cx0 + 32'd1;
      for (int dz = 0; dz < 2; dz++) begin
        cz = bz[31:0] + dz;
        cy = by[31:0];
        y0 = lerp(corner(cx0, cy, cz), corner(cx1, cy, cz), ax);
        cy = cy + 32'd1;
        y1 = lerp(corner(cx0, cy, cz), corner(cx1, cy, cz), ax);
        if (dz == 0) z0 = lerp(y0, y1, ay);
        else z1 = lerp(y0, y1, ay);
      end
      r = lerp(z0, z1, az);
      pending.push_back(r[15:0]);
    endfunction

    function void check_sample(logic [15:0] got);
      logic [15:0] want;
      if (pending.size() == 0) begin
        $error("noise_value: unexpected beat, actual %0d", $signed(got));
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        $error("noise_value: expected %0d actual %0d", $signed(want), $signed(got));
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit quiet = 0;
  noise_scoreboard sb = new();

  vn3_in_if samples();
  vn3_out_if results();
  vn3_cfg_if cfg();

  value_noise_3d_top dut (
    .clk(clk), .rst(rst), .samples(samples), .results(results), .cfg(cfg)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    samples.valid = 1'b0;
    samples.pos_x = '0;
    samples.pos_y = '0;
    samples.pos_z = '0;
    results.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = vn3_pkg::REG_WORLD_SEED;
    cfg.data = '0;
  end

  // Result side: random stall bursts until the quiet tail of the run.
  always @(posedge clk) begin
    if (!rst) begin
      if (results.valid && results.ready) sb.check_sample(results.noise_value);
      if (!quiet && $urandom_range(0, 7) == 0) begin
        results.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk) begin
          if (results.valid && results.ready) sb.check_sample(results.noise_value);
        end
        results.ready <= 1'b1;
      end else begin
        results.ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(logic [vn3_pkg::REG_IDX_W-1:0] idx, logic [63:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      vn3_pkg::REG_WORLD_SEED: sb.seed = value[31:0];
      vn3_pkg::REG_CELL_PERIOD: sb.period = value[15:0];
      default: sb.salt = value;
    endcase
    @(posedge clk);
  endtask

  task automatic send_sample(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      samples.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    samples.valid <= 1'b1;
    samples.pos_x <= x;
    samples.pos_y <= y;
    samples.pos_z <= z;
    do @(posedge clk); while (!samples.ready);
    sb.note_sample(x, y, z);
  endtask

  task automatic drain();
    samples.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 200) - 100;
      1: return $urandom();
      2: return 32'h7fffff00 + $urandom_range(0, 255);
      default: return 32'h80000000 + $urandom_range(0, 255);
    endcase
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) send_sample(rand_coord(), rand_coord(), rand_coord());
  endtask

  initial begin
    logic [31:0] edges[6];
    edges = '{32'h0, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'd15, 32'd16};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed corners of the coordinate range at the reset settings.
    for (int i = 0; i < 6; i++) send_sample(edges[i], edges[(i + 1) % 6], edges[(i + 3) % 6]);
    send_sample(32'hfffffff1, 32'd17, 32'hffffffef);
    drain();

    write_reg(vn3_pkg::REG_CELL_PERIOD, 64'd0);
    send_sample(32'd5, 32'hffffffff, 32'h7fffffff);
    send_sample(32'h80000000, 32'd0, 32'd1);
    drain();

    write_reg(vn3_pkg::REG_CELL_PERIOD, 64'hffff);
    write_reg(vn3_pkg::REG_WORLD_SEED, 64'hffffffff);
    write_reg(vn3_pkg::REG_HASH_SALT, 64'hffffffffffffffff);
    for (int i = 0; i < 6; i++) send_sample(edges[i], edges[5 - i], edges[i]);
    send_sample(32'hffff0000, 32'd65534, 32'hffff0001);
    drain();

    write_reg(vn3_pkg::REG_CELL_PERIOD, 64'd1);
    write_reg(vn3_pkg::REG_WORLD_SEED, 64'h80000000);
    write_reg(vn3_pkg::REG_HASH_SALT, 64'h0);
    send_sample(32'h7fffffff, 32'h80000000, 32'hffffffff);
    send_sample(32'd3, 32'd4, 32'd5);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(vn3_pkg::REG_CELL_PERIOD, (ph == 2) ? 64'd0 : ((ph == 4) ? 64'hffff
                                  : $urandom_range(1, 300)));
      write_reg(vn3_pkg::REG_WORLD_SEED, {32'd0, $urandom()});
      write_reg(vn3_pkg::REG_HASH_SALT, {$urandom(), $urandom()});
      if (ph == 5) quiet = 1;
      random_phase(155);
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
